// ===== hdl/sudi_pkg.sv =====
// Shared constants, codes and state type for the set union, difference and intersection block.
`timescale 1ns / 1ps

package sudi_pkg;

    // Elements per list; any value from 1 to 16.
    localparam int SET_SIZE   = 16;
    localparam int ELEM_W     = 32;
    localparam int TOTAL      = 2 * SET_SIZE;
    localparam int IDX_W      = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int FLAG_IDX_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
    localparam int SET_ID_W   = 2;

    localparam logic [SET_ID_W-1:0] SET_UNION = 2'd0;
    localparam logic [SET_ID_W-1:0] SET_DIFF  = 2'd1;
    localparam logic [SET_ID_W-1:0] SET_INTER = 2'd2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_XLAT,
        S_SCAN,
        S_DECIDE,
        S_PICK,
        S_PICKW,
        S_FLUSH
    } t_state;

endpackage

// ===== hdl/set_union_difference_intersection.sv =====
// Top level: loads two lists and emits their union, difference and intersection.
`timescale 1ns / 1ps

// Usage
// The input channel (i_valid, i_value, o_stall) takes 2*SET_SIZE beats per run:
// the first SET_SIZE fill list A, the next SET_SIZE fill list B. A beat is taken
// whenever i_valid is high while loading.
// After the last beat of B, o_stall stays high while one shared 32-bit equality
// comparator walks the lists, one pair per cycle through a single memory read port.
// Each element of the concatenation A then B is fetched, latched and compared
// with every later element, then kept or dropped; this is followed by a pass over
// the SET_SIZE flags of A for each of the difference and the intersection.
// o_stall drops once the closing beat of the intersection is registered.
// The output channel (o_valid, o_set_id, o_element, o_empty_res, o_last_of_set,
// o_last, i_stall) sends the union, then A minus B, then A intersect B. An empty
// set goes out as one beat with o_empty_res set. o_last marks the final beat.
// When the receiver stalls, the output register holds its beat and the sequencer
// waits at the next beat it must send. Synchronous reset returns the block to
// loading list A with no output pending; list contents are not cleared.
module set_union_difference_intersection (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [sudi_pkg::ELEM_W-1:0]     i_value,
    output logic                                   o_stall,
    output logic                                   o_valid,
    output logic        [sudi_pkg::SET_ID_W-1:0]   o_set_id,
    output logic signed [sudi_pkg::ELEM_W-1:0]     o_element,
    output logic                                   o_empty_res,
    output logic                                   o_last_of_set,
    output logic                                   o_last,
    input  logic                                   i_stall
);

    localparam int IW = sudi_pkg::IDX_W;
    localparam int FW = sudi_pkg::FLAG_IDX_W;
    localparam int EW = sudi_pkg::ELEM_W;
    localparam logic [IW-1:0] LAST_IDX   = IW'(sudi_pkg::TOTAL - 1);
    localparam logic [IW-1:0] LAST_A_IDX = IW'(sudi_pkg::SET_SIZE - 1);
    localparam logic [IW-1:0] B_START    = IW'(sudi_pkg::SET_SIZE);

    sudi_pkg::t_state r_state, n_state;

    logic [EW-1:0]      r_mem [sudi_pkg::TOTAL];
    logic [EW-1:0]      r_rd_data;
    logic [IW-1:0]      rd_addr;

    logic [IW-1:0]      r_load_cnt, n_load_cnt;
    logic [IW-1:0]      r_i, n_i;
    logic [IW-1:0]      r_j, n_j;
    logic [EW-1:0]      r_x, n_x;
    logic               r_hit_lo, n_hit_lo;
    logic               r_hit_hi, n_hit_hi;
    logic [EW-1:0]      r_hold, n_hold;
    logic               r_hold_v, n_hold_v;
    logic [sudi_pkg::SET_ID_W-1:0] r_set_id, n_set_id;
    logic [sudi_pkg::SET_SIZE-1:0] r_dup_a, n_dup_a;
    logic [sudi_pkg::SET_SIZE-1:0] r_in_b, n_in_b;

    logic               r_o_valid, n_o_valid;
    logic [sudi_pkg::SET_ID_W-1:0] r_o_set_id, n_o_set_id;
    logic [EW-1:0]      r_o_element, n_o_element;
    logic               r_o_empty, n_o_empty;
    logic               r_o_los, n_o_los;
    logic               r_o_last, n_o_last;

    logic               in_acc;
    logic               out_free;
    logic               hit;
    logic               keep;
    logic               sel;
    logic [FW-1:0]      flag_idx;
    logic               push_req;
    logic [EW-1:0]      push_elem;
    logic               push_empty;
    logic               push_los;

    assign in_acc   = i_valid && (r_state == sudi_pkg::S_LOAD);
    assign out_free = !r_o_valid || !i_stall;
    assign hit      = (r_rd_data == r_x);
    assign keep     = !(r_hit_lo || r_hit_hi);
    assign flag_idx = r_i[FW-1:0];
    // A last-seen element of A (no later copy in A) goes to the difference when B
    // lacks it and to the intersection when B holds it.
    assign sel      = !r_dup_a[flag_idx] &&
                      ((r_set_id == sudi_pkg::SET_DIFF) ? !r_in_b[flag_idx]
                                                        : r_in_b[flag_idx]);

    always_comb begin
        unique case (r_state)
            sudi_pkg::S_XLAT: rd_addr = r_i + IW'(1);
            sudi_pkg::S_SCAN: rd_addr = r_j + IW'(1);
            default:          rd_addr = r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_load_cnt] <= i_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sudi_pkg::S_LOAD: begin
                if (in_acc && r_load_cnt == LAST_IDX) begin
                    n_state = sudi_pkg::S_FETCH;
                end
            end
            sudi_pkg::S_FETCH: begin
                n_state = sudi_pkg::S_XLAT;
            end
            sudi_pkg::S_XLAT: begin
                n_state = (r_i == LAST_IDX) ? sudi_pkg::S_DECIDE : sudi_pkg::S_SCAN;
            end
            sudi_pkg::S_SCAN: begin
                if (r_j == LAST_IDX) begin
                    n_state = sudi_pkg::S_DECIDE;
                end
            end
            sudi_pkg::S_DECIDE: begin
                if (!keep || !r_hold_v || out_free) begin
                    n_state = (r_i == LAST_IDX) ? sudi_pkg::S_FLUSH : sudi_pkg::S_FETCH;
                end
            end
            sudi_pkg::S_PICK: begin
                if (sel) begin
                    n_state = sudi_pkg::S_PICKW;
                end else if (r_i == LAST_A_IDX) begin
                    n_state = sudi_pkg::S_FLUSH;
                end
            end
            sudi_pkg::S_PICKW: begin
                if (!r_hold_v || out_free) begin
                    n_state = (r_i == LAST_A_IDX) ? sudi_pkg::S_FLUSH : sudi_pkg::S_PICK;
                end
            end
            sudi_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_state = (r_set_id == sudi_pkg::SET_INTER) ? sudi_pkg::S_LOAD
                                                                : sudi_pkg::S_PICK;
                end
            end
            default: n_state = sudi_pkg::S_LOAD;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_load_cnt  = r_load_cnt;
        n_i         = r_i;
        n_j         = r_j;
        n_x         = r_x;
        n_hit_lo    = r_hit_lo;
        n_hit_hi    = r_hit_hi;
        n_hold      = r_hold;
        n_hold_v    = r_hold_v;
        n_set_id    = r_set_id;
        n_dup_a     = r_dup_a;
        n_in_b      = r_in_b;
        push_req    = 1'b0;
        push_elem   = r_hold;
        push_empty  = 1'b0;
        push_los    = 1'b0;

        unique case (r_state)
            sudi_pkg::S_LOAD: begin
                if (in_acc) begin
                    if (r_load_cnt == LAST_IDX) begin
                        n_load_cnt = '0;
                        n_i        = '0;
                        n_set_id   = sudi_pkg::SET_UNION;
                        n_hold_v   = 1'b0;
                    end else begin
                        n_load_cnt = r_load_cnt + IW'(1);
                    end
                end
            end
            sudi_pkg::S_FETCH: begin
            end
            sudi_pkg::S_XLAT: begin
                n_x      = r_rd_data;
                n_j      = r_i + IW'(1);
                n_hit_lo = 1'b0;
                n_hit_hi = 1'b0;
            end
            sudi_pkg::S_SCAN: begin
                if (r_j < B_START) begin
                    n_hit_lo = r_hit_lo || hit;
                end else begin
                    n_hit_hi = r_hit_hi || hit;
                end
                n_j = r_j + IW'(1);
            end
            sudi_pkg::S_DECIDE: begin
                // A kept element first releases the one held back, which is not last.
                if (keep && r_hold_v) begin
                    push_req = 1'b1;
                end
                if (!keep || !r_hold_v || out_free) begin
                    if (keep) begin
                        n_hold   = r_x;
                        n_hold_v = 1'b1;
                    end
                    if (r_i < B_START) begin
                        n_dup_a[flag_idx] = r_hit_lo;
                        n_in_b[flag_idx]  = r_hit_hi;
                    end
                    if (r_i != LAST_IDX) begin
                        n_i = r_i + IW'(1);
                    end
                end
            end
            sudi_pkg::S_PICK: begin
                if (!sel && r_i != LAST_A_IDX) begin
                    n_i = r_i + IW'(1);
                end
            end
            sudi_pkg::S_PICKW: begin
                if (r_hold_v) begin
                    push_req = 1'b1;
                end
                if (!r_hold_v || out_free) begin
                    n_hold   = r_rd_data;
                    n_hold_v = 1'b1;
                    if (r_i != LAST_A_IDX) begin
                        n_i = r_i + IW'(1);
                    end
                end
            end
            sudi_pkg::S_FLUSH: begin
                push_req   = 1'b1;
                push_los   = 1'b1;
                push_empty = !r_hold_v;
                push_elem  = r_hold_v ? r_hold : '0;
                if (out_free) begin
                    n_hold_v = 1'b0;
                    n_i      = '0;
                    if (r_set_id == sudi_pkg::SET_UNION) begin
                        n_set_id = sudi_pkg::SET_DIFF;
                    end else if (r_set_id == sudi_pkg::SET_DIFF) begin
                        n_set_id = sudi_pkg::SET_INTER;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_o_valid   = r_o_valid;
        n_o_set_id  = r_o_set_id;
        n_o_element = r_o_element;
        n_o_empty   = r_o_empty;
        n_o_los     = r_o_los;
        n_o_last    = r_o_last;
        if (push_req && out_free) begin
            n_o_valid   = 1'b1;
            n_o_set_id  = r_set_id;
            n_o_element = push_elem;
            n_o_empty   = push_empty;
            n_o_los     = push_los;
            n_o_last    = push_los && (r_set_id == sudi_pkg::SET_INTER);
        end else if (!i_stall) begin
            n_o_valid   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sudi_pkg::S_LOAD;
            r_load_cnt <= '0;
            r_hold_v   <= 1'b0;
            r_o_valid  <= 1'b0;
            r_set_id   <= sudi_pkg::SET_UNION;
            r_i        <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_hold_v   <= n_hold_v;
            r_o_valid  <= n_o_valid;
            r_set_id   <= n_set_id;
            r_i        <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j         <= n_j;
        r_x         <= n_x;
        r_hit_lo    <= n_hit_lo;
        r_hit_hi    <= n_hit_hi;
        r_hold      <= n_hold;
        r_dup_a     <= n_dup_a;
        r_in_b      <= n_in_b;
        r_o_set_id  <= n_o_set_id;
        r_o_element <= n_o_element;
        r_o_empty   <= n_o_empty;
        r_o_los     <= n_o_los;
        r_o_last    <= n_o_last;
    end

    assign o_stall       = (r_state != sudi_pkg::S_LOAD);
    assign o_valid       = r_o_valid;
    assign o_set_id      = r_o_set_id;
    assign o_element     = r_o_element;
    assign o_empty_res   = r_o_empty;
    assign o_last_of_set = r_o_los;
    assign o_last        = r_o_last;

endmodule

// ===== hdl/sudi_checker.sv =====
// Port-level checker for the set union, difference and intersection block, with its bind.
`timescale 1ns / 1ps

module sudi_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_valid,
    input logic        [sudi_pkg::SET_ID_W-1:0] o_set_id,
    input logic signed [sudi_pkg::ELEM_W-1:0]   o_element,
    input logic                                 o_empty_res,
    input logic                                 o_last_of_set,
    input logic                                 o_last,
    input logic                                 i_stall
);

    // A stalled output beat must stay in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_element) && $stable(o_set_id) &&
                               $stable(o_last_of_set) && $stable(o_empty_res))
        else $error("output beat changed while stalled");

    // An empty set is a single zero beat that closes the set.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_element == '0 && o_last_of_set)
        else $error("empty beat malformed");

    // The run ends only on the closing beat of the intersection.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_last_of_set && o_set_id == sudi_pkg::SET_INTER)
        else $error("final beat not at end of intersection");

    // After the union closes, the next beat belongs to the difference.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_of_set && o_set_id == sudi_pkg::SET_UNION
        |=> !o_valid || o_set_id == sudi_pkg::SET_DIFF)
        else $error("set order broken after union");

endmodule

bind set_union_difference_intersection sudi_checker u_sudi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .o_set_id      (o_set_id),
    .o_element     (o_element),
    .o_empty_res   (o_empty_res),
    .o_last_of_set (o_last_of_set),
    .o_last        (o_last),
    .i_stall       (i_stall)
);
